// ===== src/pcs_pkg.sv =====
// Shared types and constants for the prime classifier with session statistics.
// Used by the channel interfaces, the serial divider and the top level.
package pcs_pkg;

  localparam int VALUE_W = 16;
  localparam int CNT_W   = 16;
  localparam int SUM_W   = 32;
  localparam int STEP_W  = $clog2(SUM_W);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_TRIAL,
    S_WAIT,
    S_UPDATE,
    S_AVG,
    S_AVG_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] quotient;
    logic [CNT_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== src/pcs_ifs.sv =====
// Valid/ready channel interfaces for input beats and result beats.
// Depends on pcs_pkg for field widths.
interface pcs_item_if;
  logic                        valid;
  logic                        ready;
  logic [pcs_pkg::VALUE_W-1:0] value;
  logic                        finish;

  modport source(output valid, output value, output finish, input ready);
  modport sink(input valid, input value, input finish, output ready);
endinterface

interface pcs_result_if;
  logic                      valid;
  logic                      ready;
  logic                      is_prime;
  logic                      summary_valid;
  logic [pcs_pkg::VALUE_W-1:0] largest;
  logic [pcs_pkg::CNT_W-1:0] largest_position;
  logic [pcs_pkg::CNT_W-1:0] prime_count;
  logic [pcs_pkg::SUM_W-1:0] prime_sum;
  logic [pcs_pkg::CNT_W-1:0] prime_average;
  logic [pcs_pkg::CNT_W-1:0] other_count;
  logic [pcs_pkg::SUM_W-1:0] other_sum;
  logic [pcs_pkg::CNT_W-1:0] other_average;

  modport source(output valid, output is_prime, output summary_valid, output largest,
                 output largest_position, output prime_count, output prime_sum,
                 output prime_average, output other_count, output other_sum,
                 output other_average, input ready);
  modport sink(input valid, input is_prime, input summary_valid, input largest,
               input largest_position, input prime_count, input prime_sum,
               input prime_average, input other_count, input other_sum,
               input other_average, output ready);
endinterface

// ===== src/pcs_sdiv.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on pcs_pkg for the request and response structs.
module pcs_sdiv (
  input  logic              clk,
  input  logic              rst,
  input  pcs_pkg::div_req_t req,
  output pcs_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [pcs_pkg::STEP_W-1:0]    cnt;
  logic [pcs_pkg::SUM_W-1:0]     quo;
  logic [pcs_pkg::CNT_W-1:0]     rem;
  logic [pcs_pkg::CNT_W-1:0]     dvs;
  logic [pcs_pkg::CNT_W:0]       trial;
  logic [pcs_pkg::CNT_W:0]       diff;
  logic                          ge;

  assign trial = {rem, quo[pcs_pkg::SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        quo <= {quo[pcs_pkg::SUM_W-2:0], ge};
        rem <= ge ? diff[pcs_pkg::CNT_W-1:0] : trial[pcs_pkg::CNT_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == pcs_pkg::STEP_W'(pcs_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ===== src/prime_classify_stats.sv =====
// Prime classifier by trial division over odd divisors, with session statistics.
// Trial division and the two averages on a finish beat all share the one serial divider;
// odd trial divisors run up to sqrt(value), and an average with a zero count skips its divide.
// Throughput: one beat at a time; the next beat is taken once the previous result is staged.
// Reset: synchronous; clears FSM, divider, output valid and session counts, sums, largest.
// Depends on pcs_pkg, pcs_ifs and pcs_sdiv.
module prime_classify_stats #(
  parameter int VALUE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  pcs_item_if.sink             items,
  pcs_result_if.source         results
);

  localparam int VW  = (VALUE_BITS < pcs_pkg::VALUE_W) ? VALUE_BITS : pcs_pkg::VALUE_W;
  localparam int DW  = VW / 2 + 2;
  localparam int SQW = VW + 2;

  pcs_pkg::state_t   state, state_next;
  pcs_pkg::div_req_t div_req;
  pcs_pkg::div_rsp_t div_rsp;

  logic [VW-1:0]              n;
  logic                       fin;
  logic [DW-1:0]              d;
  logic [SQW-1:0]             sq;
  logic                       prime;
  logic                       sel;
  logic [pcs_pkg::CNT_W-1:0]  avg_p;
  logic [pcs_pkg::CNT_W-1:0]  avg_o;
  logic                       load_out;

  logic [VW-1:0]              best_value;
  logic [pcs_pkg::CNT_W-1:0]  best_position;
  logic [pcs_pkg::CNT_W-1:0]  items_seen;
  logic [pcs_pkg::CNT_W-1:0]  primes_seen;
  logic [pcs_pkg::SUM_W-1:0]  primes_total;
  logic [pcs_pkg::CNT_W-1:0]  others_seen;
  logic [pcs_pkg::SUM_W-1:0]  others_total;

  logic [pcs_pkg::CNT_W-1:0]  items_seen_next;
  logic [pcs_pkg::CNT_W-1:0]  cls_count;
  logic [pcs_pkg::SUM_W-1:0]  cls_total;
  logic [pcs_pkg::CNT_W-1:0]  cls_count_next;
  logic [pcs_pkg::SUM_W:0]    cls_sum_wide;
  logic [pcs_pkg::SUM_W-1:0]  cls_total_next;
  logic [pcs_pkg::CNT_W-1:0]  avg_count;
  logic [pcs_pkg::SUM_W-1:0]  avg_total;
  logic [pcs_pkg::CNT_W-1:0]  avg_quot;

  logic                       out_valid;
  logic                       o_is_prime;
  logic                       o_summary;
  logic [pcs_pkg::VALUE_W-1:0] o_largest;
  logic [pcs_pkg::CNT_W-1:0]  o_position;
  logic [pcs_pkg::CNT_W-1:0]  o_prime_count;
  logic [pcs_pkg::SUM_W-1:0]  o_prime_sum;
  logic [pcs_pkg::CNT_W-1:0]  o_prime_average;
  logic [pcs_pkg::CNT_W-1:0]  o_other_count;
  logic [pcs_pkg::SUM_W-1:0]  o_other_sum;
  logic [pcs_pkg::CNT_W-1:0]  o_other_average;

  pcs_sdiv u_sdiv (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign items_seen_next = (items_seen == pcs_pkg::CNT_MAX) ? items_seen
                                                            : items_seen + 1'b1;
  assign cls_count       = prime ? primes_seen : others_seen;
  assign cls_total       = prime ? primes_total : others_total;
  assign cls_count_next  = (cls_count == pcs_pkg::CNT_MAX) ? cls_count : cls_count + 1'b1;
  assign cls_sum_wide    = {1'b0, cls_total} + (pcs_pkg::SUM_W + 1)'(n);
  assign cls_total_next  = cls_sum_wide[pcs_pkg::SUM_W] ? pcs_pkg::SUM_MAX
                                                         : cls_sum_wide[pcs_pkg::SUM_W-1:0];
  assign avg_count       = sel ? others_seen : primes_seen;
  assign avg_total       = sel ? others_total : primes_total;
  assign avg_quot        = (div_rsp.quotient[pcs_pkg::SUM_W-1:pcs_pkg::CNT_W] != '0)
                           ? pcs_pkg::CNT_MAX : div_rsp.quotient[pcs_pkg::CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = pcs_pkg::SUM_W'(n);
    div_req.divisor  = pcs_pkg::CNT_W'(d);
    load_out         = 1'b0;
    unique case (state)
      pcs_pkg::S_IDLE: begin
        if (items.valid) state_next = pcs_pkg::S_CLASS;
      end
      pcs_pkg::S_CLASS: begin
        if (n < VW'(2) || !n[0]) state_next = pcs_pkg::S_UPDATE;
        else state_next = pcs_pkg::S_TRIAL;
      end
      pcs_pkg::S_TRIAL: begin
        if (sq > SQW'(n)) begin
          state_next = pcs_pkg::S_UPDATE;
        end else begin
          div_req.start = 1'b1;
          state_next    = pcs_pkg::S_WAIT;
        end
      end
      pcs_pkg::S_WAIT: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.remainder == '0) ? pcs_pkg::S_UPDATE : pcs_pkg::S_TRIAL;
        end
      end
      pcs_pkg::S_UPDATE: begin
        state_next = fin ? pcs_pkg::S_AVG : pcs_pkg::S_EMIT;
      end
      pcs_pkg::S_AVG: begin
        div_req.dividend = avg_total;
        div_req.divisor  = avg_count;
        if (avg_count != '0) begin
          div_req.start = 1'b1;
          state_next    = pcs_pkg::S_AVG_WAIT;
        end else if (sel) begin
          state_next = pcs_pkg::S_EMIT;
        end
      end
      pcs_pkg::S_AVG_WAIT: begin
        if (div_rsp.done) state_next = sel ? pcs_pkg::S_EMIT : pcs_pkg::S_AVG;
      end
      pcs_pkg::S_EMIT: begin
        if (!out_valid || results.ready) begin
          load_out   = 1'b1;
          state_next = pcs_pkg::S_IDLE;
        end
      end
      default: state_next = pcs_pkg::S_IDLE;
    endcase
  end

  assign items.ready = (state == pcs_pkg::S_IDLE);

  // Datapath: classification, statistics and averages.
  always_ff @(posedge clk) begin
    if (rst) begin
      best_value    <= '0;
      best_position <= '0;
      items_seen    <= '0;
      primes_seen   <= '0;
      primes_total  <= '0;
      others_seen   <= '0;
      others_total  <= '0;
    end else begin
      unique case (state)
        pcs_pkg::S_IDLE: begin
          if (items.valid) begin
            n   <= items.value[VW-1:0];
            fin <= items.finish;
          end
        end
        pcs_pkg::S_CLASS: begin
          prime <= (n == VW'(2)) || (n >= VW'(2) && n[0]);
          d     <= DW'(3);
          sq    <= SQW'(9);
        end
        pcs_pkg::S_TRIAL: ;
        pcs_pkg::S_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.remainder == '0) begin
              prime <= 1'b0;
            end else begin
              sq <= sq + SQW'({d, 2'b00}) + SQW'(4);
              d  <= d + DW'(2);
            end
          end
        end
        pcs_pkg::S_UPDATE: begin
          items_seen <= items_seen_next;
          if (prime) begin
            primes_seen  <= cls_count_next;
            primes_total <= cls_total_next;
          end else begin
            others_seen  <= cls_count_next;
            others_total <= cls_total_next;
          end
          if (n >= best_value) begin
            best_value    <= n;
            best_position <= items_seen_next;
          end
          sel <= 1'b0;
        end
        pcs_pkg::S_AVG: begin
          if (avg_count == '0) begin
            if (sel) avg_o <= '0;
            else avg_p <= '0;
            sel <= 1'b1;
          end
        end
        pcs_pkg::S_AVG_WAIT: begin
          if (div_rsp.done) begin
            if (sel) avg_o <= avg_quot;
            else avg_p <= avg_quot;
            sel <= 1'b1;
          end
        end
        pcs_pkg::S_EMIT: begin
          if (load_out && fin) begin
            best_value    <= '0;
            best_position <= '0;
            items_seen    <= '0;
            primes_seen   <= '0;
            primes_total  <= '0;
            others_seen   <= '0;
            others_total  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output stage: hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_is_prime      <= prime;
      o_summary       <= fin;
      o_largest       <= fin ? pcs_pkg::VALUE_W'(best_value) : '0;
      o_position      <= fin ? best_position : '0;
      o_prime_count   <= fin ? primes_seen : '0;
      o_prime_sum     <= fin ? primes_total : '0;
      o_prime_average <= fin ? avg_p : '0;
      o_other_count   <= fin ? others_seen : '0;
      o_other_sum     <= fin ? others_total : '0;
      o_other_average <= fin ? avg_o : '0;
    end
  end

  assign results.valid            = out_valid;
  assign results.is_prime         = o_is_prime;
  assign results.summary_valid    = o_summary;
  assign results.largest          = o_largest;
  assign results.largest_position = o_position;
  assign results.prime_count      = o_prime_count;
  assign results.prime_sum        = o_prime_sum;
  assign results.prime_average    = o_prime_average;
  assign results.other_count      = o_other_count;
  assign results.other_sum        = o_other_sum;
  assign results.other_average    = o_other_average;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready |=> state == pcs_pkg::S_CLASS)
    else $error("accepted beat did not start classification");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    load_out && fin |=> items_seen == '0 && primes_total == '0 && others_total == '0)
    else $error("session state not cleared after finish beat");

  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.summary_valid |->
      results.prime_count == '0 && results.largest == '0 && results.other_sum == '0)
    else $error("summary fields nonzero on a plain beat");

endmodule
